@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by pod_queue, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define POD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pod assertion failed");

// expression must never be true outside reset
`define POD_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("pod assertion failed");

`else

`define POD_ASSERT(name, clk, rst_n, prop)
`define POD_ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

@@ hdl/pod_pkg.sv @@
// ----------------------------------------------------------------------------
// pod_pkg
// types, widths and tables shared by the period overlap day counter
// ----------------------------------------------------------------------------
`default_nettype none

package pod_pkg;

  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned DATE_W      = YEAR_W + MONTH_W + DAY_W;
  localparam int unsigned NUM_DATES   = 4;
  localparam int unsigned IN_TDATA_W  = ((NUM_DATES * DATE_W + 7) / 8) * 8;

  localparam int unsigned CNT_W       = 22;
  localparam int unsigned OUT_TDATA_W = ((CNT_W + 7) / 8) * 8;

  // running day number of a 14-bit year fits 23 bits
  localparam int unsigned DNUM_W      = 23;
  localparam int unsigned Q100_W      = 8;
  localparam int unsigned MOFF_W      = 9;

  localparam int unsigned YEAR_MAX_DEF = 9999;
  localparam int unsigned YEAR_CMP_W   = 17;

  localparam logic [CNT_W-1:0] OVERLAP_SAT = '1;

  // floor(q / 25) for q < 4096 as (q * 5243) >> 17
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
  localparam int unsigned PROD_W      = YEAR_W - 2 + RECIP_W;

  // queue depth must stay a power of two so the pointers wrap on their own
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  // one date reduced to the terms of its day number
  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MOFF_W-1:0] moff;
    logic [Q100_W-1:0] q100;
    logic [YEAR_W-1:0] year;
  } prep_t;

  typedef struct packed {
    logic                      bad;
    prep_t [NUM_DATES-1:0]     dates;
  } entry_t;

  // days from march 1st to the first of the month, year starting in march
  function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
    logic [MOFF_W-1:0] ofs;
    case (month)
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

`default_nettype wire

@@ hdl/pod_front.sv @@
// ----------------------------------------------------------------------------
// pod_front
// accepts date pairs, checks every date and reduces it to day number terms
// ----------------------------------------------------------------------------
`default_nettype none

module pod_front #(
  parameter int unsigned YEAR_MAX = pod_pkg::YEAR_MAX_DEF
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      in_valid_i,
  output logic                                     in_ready_o,
  input  pod_pkg::date_t [pod_pkg::NUM_DATES-1:0]  in_dates_i,
  output logic                                     out_valid_o,
  input  wire                                      out_ready_i,
  output pod_pkg::entry_t                          out_entry_o
);

  localparam logic [pod_pkg::YEAR_CMP_W-1:0] YearMaxW = pod_pkg::YEAR_CMP_W'(YEAR_MAX);

  function automatic logic [pod_pkg::DAY_W-1:0] month_days(
    input logic [pod_pkg::MONTH_W-1:0] month,
    input logic                        leap
  );
    logic [pod_pkg::DAY_W-1:0] n;
    case (month)
      4'd2:                    n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  logic                                     s1_v_q, s2_v_q;
  logic                                     s1_rdy, s2_rdy;
  pod_pkg::date_t [pod_pkg::NUM_DATES-1:0]  s1_date_q;
  logic [pod_pkg::Q100_W-1:0]               s1_q100_q [pod_pkg::NUM_DATES];
  logic [pod_pkg::Q100_W-1:0]               q100_d    [pod_pkg::NUM_DATES];
  pod_pkg::entry_t                          s2_entry_q, s2_entry_d;

  assign s2_rdy      = !s2_v_q || out_ready_i;
  assign s1_rdy      = !s1_v_q || s2_rdy;
  assign in_ready_o  = s1_rdy;
  assign out_valid_o = s2_v_q;
  assign out_entry_o = s2_entry_q;

  // year / 100 as (year / 4) / 25 by reciprocal
  always_comb begin
    logic [pod_pkg::PROD_W-1:0] prod;
    for (int i = 0; i < pod_pkg::NUM_DATES; i++) begin
      prod      = pod_pkg::PROD_W'(in_dates_i[i].year[pod_pkg::YEAR_W-1:2])
                * pod_pkg::PROD_W'(pod_pkg::RECIP_25);
      q100_d[i] = prod[pod_pkg::RECIP_SHIFT +: pod_pkg::Q100_W];
    end
  end

  always_comb begin
    logic                             cent;
    logic                             leap;
    logic                             ok;
    logic                             early;
    logic [pod_pkg::YEAR_W-1:0]       yr;
    logic [pod_pkg::MONTH_W-1:0]      mo;
    logic [pod_pkg::DAY_W-1:0]        dy;
    s2_entry_d     = '0;
    for (int i = 0; i < pod_pkg::NUM_DATES; i++) begin
      yr    = s1_date_q[i].year;
      mo    = s1_date_q[i].month;
      dy    = s1_date_q[i].day;
      cent  = (15'(s1_q100_q[i]) * 15'd100) == 15'(yr);
      // divisible by 100 and by 16 means divisible by 400
      leap  = (yr[1:0] == 2'd0) && (!cent || (yr[3:0] == 4'd0));
      ok    = (yr != '0) && (pod_pkg::YEAR_CMP_W'(yr) <= YearMaxW)
           && (mo != '0) && (mo <= 4'd12)
           && (dy != '0) && (dy <= month_days(mo, leap));
      // january and february count as the end of the previous year
      early = (mo <= 4'd2);
      s2_entry_d.dates[i].year = early ? yr - 1'b1 : yr;
      s2_entry_d.dates[i].q100 = (early && cent) ? s1_q100_q[i] - 1'b1 : s1_q100_q[i];
      s2_entry_d.dates[i].moff = pod_pkg::month_offset(mo);
      s2_entry_d.dates[i].day  = dy;
      if (!ok) begin
        s2_entry_d.bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_date_q <= in_dates_i;
      for (int i = 0; i < pod_pkg::NUM_DATES; i++) begin
        s1_q100_q[i] <= q100_d[i];
      end
    end
    if (s2_rdy && s1_v_q) begin
      s2_entry_q <= s2_entry_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pod_queue.sv @@
// ----------------------------------------------------------------------------
// pod_queue
// short request queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pod_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_valid_i,
  output logic             push_ready_o,
  input  pod_pkg::entry_t  push_data_i,
  output logic             pop_valid_o,
  input  wire              pop_ready_i,
  output pod_pkg::entry_t  pop_data_o
);

  pod_pkg::entry_t                  mem_q [pod_pkg::QUEUE_DEPTH];
  logic [pod_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [pod_pkg::QUEUE_CNT_W-1:0]  cnt_q;
  logic                             push, pop;

  assign push_ready_o = (cnt_q != pod_pkg::QUEUE_CNT_W'(pod_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `POD_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni,
    cnt_q > pod_pkg::QUEUE_CNT_W'(pod_pkg::QUEUE_DEPTH))
  `POD_ASSERT(a_push_counts, clk_i, rst_ni,
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
  `POD_ASSERT(a_pop_counts, clk_i, rst_ni,
    (pop && !push) |=> (cnt_q == $past(cnt_q) - 1'b1))

endmodule

`default_nettype wire

@@ hdl/pod_back.sv @@
// ----------------------------------------------------------------------------
// pod_back
// forms day numbers, intersects the two periods and registers the result
// ----------------------------------------------------------------------------
`default_nettype none

module pod_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  pod_pkg::entry_t              in_entry_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [pod_pkg::CNT_W-1:0]    out_cnt_o,
  output logic                         out_bad_o
);

  logic                          b1_v_q, b2_v_q, b3_v_q;
  logic                          b1_rdy, b2_rdy, b3_rdy;
  logic                          b1_bad_q, b2_bad_q, b3_bad_q;
  logic [pod_pkg::DNUM_W-1:0]    num_d  [pod_pkg::NUM_DATES];
  logic [pod_pkg::DNUM_W-1:0]    num_q  [pod_pkg::NUM_DATES];
  logic [pod_pkg::DNUM_W-1:0]    lo_q, hi_q, lo_d, hi_d;
  logic                          rev_d;
  logic [pod_pkg::DNUM_W:0]      span;
  logic [pod_pkg::CNT_W-1:0]     cnt_d, cnt_q;

  assign b3_rdy      = !b3_v_q || out_ready_i;
  assign b2_rdy      = !b2_v_q || b3_rdy;
  assign b1_rdy      = !b1_v_q || b2_rdy;
  assign in_ready_o  = b1_rdy;
  assign out_valid_o = b3_v_q;
  assign out_cnt_o   = cnt_q;
  assign out_bad_o   = b3_bad_q;

  // 365*y + y/4 - y/100 + y/400 + month offset + day - 1
  always_comb begin
    pod_pkg::prep_t p;
    for (int i = 0; i < pod_pkg::NUM_DATES; i++) begin
      p        = in_entry_i.dates[i];
      num_d[i] = pod_pkg::DNUM_W'(p.year) * 23'd365
               + pod_pkg::DNUM_W'(p.year[pod_pkg::YEAR_W-1:2])
               - pod_pkg::DNUM_W'(p.q100)
               + pod_pkg::DNUM_W'(p.q100[pod_pkg::Q100_W-1:2])
               + pod_pkg::DNUM_W'(p.moff)
               + pod_pkg::DNUM_W'(p.day)
               - 1'b1;
    end
  end

  always_comb begin
    rev_d = (num_q[1] < num_q[0]) || (num_q[3] < num_q[2]);
    lo_d  = (num_q[0] > num_q[2]) ? num_q[0] : num_q[2];
    hi_d  = (num_q[1] < num_q[3]) ? num_q[1] : num_q[3];
  end

  always_comb begin
    span  = {1'b0, hi_q} - {1'b0, lo_q} + 1'b1;
    cnt_d = '0;
    if (!b2_bad_q && (hi_q >= lo_q)) begin
      if (span > (pod_pkg::DNUM_W + 1)'(pod_pkg::OVERLAP_SAT)) begin
        cnt_d = pod_pkg::OVERLAP_SAT;
      end else begin
        cnt_d = span[pod_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
    end else begin
      if (b1_rdy) begin
        b1_v_q <= in_valid_i;
      end
      if (b2_rdy) begin
        b2_v_q <= b1_v_q;
      end
      if (b3_rdy) begin
        b3_v_q <= b2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_rdy && in_valid_i) begin
      b1_bad_q <= in_entry_i.bad;
      for (int i = 0; i < pod_pkg::NUM_DATES; i++) begin
        num_q[i] <= num_d[i];
      end
    end
    if (b2_rdy && b1_v_q) begin
      b2_bad_q <= b1_bad_q || rev_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
    end
    if (b3_rdy && b2_v_q) begin
      b3_bad_q <= b2_bad_q;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/period_overlap_day_counter.sv @@
// ----------------------------------------------------------------------------
// period_overlap_day_counter
// inclusive count of days shared by two gregorian date periods
// ----------------------------------------------------------------------------
// One request carries two periods (start and end date each). The block takes
// one request per clock cycle, sustained while the output is not stalled, and
// returns one result per request: two front stages check the dates and divide
// the years by 100 with a reciprocal multiply, a two-entry queue decouples the
// sides, and three back stages form day numbers, intersect the periods and
// register the result. The per-date constant multiplies in the front and back
// stages set the clock rate.
// A bad date or a reversed period returns a count of 0 with tuser set.
// ----------------------------------------------------------------------------
`default_nettype none

module period_overlap_day_counter #(
  parameter int unsigned YEAR_MAX = pod_pkg::YEAR_MAX_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // per date, from bit 0 up: first_start, first_end, second_start, second_end,
  // each year[13:0], month[17:14], day[22:18]; bits 95:92 zero
  input  wire  [pod_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // overlap_days[21:0], bits 23:22 zero
  output logic [pod_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // bad_input
  output logic                                 m_axis_tuser
);

  pod_pkg::date_t [pod_pkg::NUM_DATES-1:0]  dates;
  pod_pkg::entry_t                          fq_entry, qb_entry;
  logic                                     fq_valid, fq_ready, qb_valid, qb_ready;
  logic [pod_pkg::CNT_W-1:0]                cnt;

  for (genvar g = 0; g < pod_pkg::NUM_DATES; g++) begin : g_unpack
    assign dates[g] = pod_pkg::date_t'(s_axis_tdata[g*pod_pkg::DATE_W +: pod_pkg::DATE_W]);
  end

  pod_front #(
    .YEAR_MAX (YEAR_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_dates_i  (dates),
    .out_valid_o (fq_valid),
    .out_ready_i (fq_ready),
    .out_entry_o (fq_entry)
  );

  pod_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_entry),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_entry)
  );

  pod_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (qb_valid),
    .in_ready_o  (qb_ready),
    .in_entry_i  (qb_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_cnt_o   (cnt),
    .out_bad_o   (m_axis_tuser)
  );

  assign m_axis_tdata = pod_pkg::OUT_TDATA_W'(cnt);

endmodule

`default_nettype wire
